@@ design/skset_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skset_pkg
// Shared constants for the sorted key set: command and status codes,
// field widths and the default capacity.
// ----------------------------------------------------------------------------
package skset_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W = 6;
  localparam int OCC_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

@@ design/skset_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skset_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module skset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sorted_key_set_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_core
// Bounded set of distinct signed 32-bit keys kept in ascending order, with
// insert, remove and search requests, one result per request.
// ----------------------------------------------------------------------------
// One request is worked at a time. The keys live in a single RAM with one
// read and one write port, and that port pair sets the timing: a request
// first scans the list from rank 0 at one entry per cycle until it meets the
// first key not below the requested one, then an insert or remove moves the
// tail of the list by one place at one entry per cycle. A finished result
// that is not yet taken holds the block before it goes back to idle.
// s_tready is high only while the block waits for a request; a finished
// result sits in the output register until taken, and a new request may be
// accepted meanwhile (its own result then waits for the slot to free).
// Status: 0 success or found, 1 duplicate, 2 not present, 3 full. Position
// is the rank when status is 0 and zero otherwise; occupancy is the count
// after the request. Command code 3 does nothing and reports not present.
// No memory clear follows reset: entries beyond the count may be read ahead, but their data is never used.
// ----------------------------------------------------------------------------
module sorted_key_set_core #(
  parameter int CAPACITY = skset_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key (signed)
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [7:2] position, [14:8] occupancy
);

  import skset_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_INS_WR = 3'd3;
  localparam logic [2:0] S_INS_KEY = 3'd4;
  localparam logic [2:0] S_DEL_WR = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]              state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        idx, idx_next;      // scan index, then insert/remove rank
  logic [CNT_W-1:0]        ptr, ptr_next;      // shift destination
  logic                    held, held_next;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic [CNT_W-1:0]        res_pos, res_pos_next;

  logic                    ram_we;
  logic [CNT_W-1:0]        ram_waddr_w, ram_raddr_w;
  logic [KEY_W-1:0]        ram_wdata, ram_rdata;
  logic                    key_lt, key_eq;
  logic [CNT_W+POS_W-1:0]  pos_ext;
  logic [CNT_W+OCC_W-1:0]  occ_ext;

  skset_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr_w[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr_w[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign key_lt   = $signed(ram_rdata) < key;
  assign key_eq   = $signed(ram_rdata) == key;

  // Read address: prefetch the next entry each cycle so the scan and the
  // shifts move one entry per cycle.
  always_comb begin
    case (state)
      S_CMP:    ram_raddr_w = idx + ONE;
      S_DECIDE: ram_raddr_w = (cmd == CMD_INSERT) ? (count - ONE) : (idx + ONE);
      S_INS_WR: ram_raddr_w = ptr - TWO;
      S_DEL_WR: ram_raddr_w = ptr + TWO;
      default:  ram_raddr_w = '0;
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    ptr_next        = ptr;
    held_next       = held;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_waddr_w     = ptr;
    ram_wdata       = ram_rdata;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          idx_next   = '0;
          held_next  = 1'b0;
          state_next = (count == '0) ? S_DECIDE : S_CMP;
        end
      end

      // Find the first held key not below the request key.
      S_CMP: begin
        if (key_lt) begin
          idx_next = idx + ONE;
          if (idx + ONE == count) begin
            state_next = S_DECIDE;
          end
        end else begin
          held_next  = key_eq;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_status_next = ST_ABSENT;
        res_pos_next    = '0;
        state_next      = S_OUT;
        case (cmd)
          CMD_INSERT: begin
            if (held) begin
              res_status_next = ST_DUP;
            end else if (count == CAP_C) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_OK;
              res_pos_next    = idx;
              ptr_next        = count;
              state_next      = (idx == count) ? S_INS_KEY : S_INS_WR;
            end
          end
          CMD_REMOVE: begin
            if (held) begin
              res_status_next = ST_OK;
              res_pos_next    = idx;
              ptr_next        = idx;
              if (idx + ONE == count) begin
                count_next = count - ONE;
              end else begin
                state_next = S_DEL_WR;
              end
            end
          end
          CMD_SEARCH: begin
            if (held) begin
              res_status_next = ST_OK;
              res_pos_next    = idx;
            end
          end
          default: begin
            res_status_next = ST_ABSENT;
          end
        endcase
      end

      // Move the tail up one place, from the top entry down to the rank.
      S_INS_WR: begin
        ram_we   = 1'b1;
        ptr_next = ptr - ONE;
        if (ptr - ONE == idx) begin
          state_next = S_INS_KEY;
        end
      end

      S_INS_KEY: begin
        ram_we      = 1'b1;
        ram_waddr_w = idx;
        ram_wdata   = key;
        count_next  = count + ONE;
        state_next  = S_OUT;
      end

      // Move the tail down one place over the removed entry.
      S_DEL_WR: begin
        ram_we   = 1'b1;
        ptr_next = ptr + ONE;
        if (ptr + TWO == count) begin
          count_next = count - ONE;
          state_next = S_OUT;
        end
      end

      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign pos_ext = {{POS_W{1'b0}}, res_pos};
  assign occ_ext = {{OCC_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    ptr        <= ptr_next;
    held       <= held_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (state == S_IDLE && s_tvalid) begin
      cmd <= s_tuser;
      key <= s_tdata;
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, occ_ext[OCC_W-1:0], pos_ext[POS_W-1:0], res_status};
    end
  end

endmodule
